// File: rtl/tblmc_pkg.sv
// Shared types, constants and the blink period table for the LED mode controller.
package tblmc_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned DebounceW = 8;
    localparam int unsigned StableW   = 10;
    localparam int unsigned SpeedW    = 4;
    localparam int unsigned PeriodW   = 10;
    localparam int unsigned CfgIdxW   = 1;
    localparam int unsigned CfgDataW  = 10;

    localparam logic [DebounceW-1:0] DebounceReset = 8'd10;
    localparam logic [StableW-1:0]   StableReset   = 10'd50;
    localparam logic [SpeedW-1:0]    SpeedMax      = 4'd10;
    localparam logic [SpeedW-1:0]    SpeedReset    = 4'd1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_STABLE   = 1'b1;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_BOTH     = 3'd1,
        MODE_LED1     = 3'd2,
        MODE_LED2     = 3'd3,
        MODE_ALT      = 3'd4,
        MODE_TOGETHER = 3'd5
    } led_mode_t;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_BTN1 = 2'd1,
        LEAD_BTN2 = 2'd2
    } lead_t;

    // per-button status after edge filtering and stability tracking
    typedef struct packed {
        logic handled;
        logic stable;
        logic held;
    } btn_status_t;

    // blink half-period: 2000/(2*s) for alternate, 2000/(5*s) for blink together
    function automatic logic [PeriodW-1:0] blink_period(input logic alt,
                                                        input logic [SpeedW-1:0] speed);
        logic [PeriodW-1:0] p_alt;
        logic [PeriodW-1:0] p_tog;
        case (speed)
            4'd0, 4'd1: begin p_alt = 10'd1000; p_tog = 10'd400; end
            4'd2:       begin p_alt = 10'd500;  p_tog = 10'd200; end
            4'd3:       begin p_alt = 10'd333;  p_tog = 10'd133; end
            4'd4:       begin p_alt = 10'd250;  p_tog = 10'd100; end
            4'd5:       begin p_alt = 10'd200;  p_tog = 10'd80;  end
            4'd6:       begin p_alt = 10'd166;  p_tog = 10'd66;  end
            4'd7:       begin p_alt = 10'd142;  p_tog = 10'd57;  end
            4'd8:       begin p_alt = 10'd125;  p_tog = 10'd50;  end
            4'd9:       begin p_alt = 10'd111;  p_tog = 10'd44;  end
            default:    begin p_alt = 10'd100;  p_tog = 10'd40;  end
        endcase
        return alt ? p_alt : p_tog;
    endfunction

endpackage

// File: rtl/tblmc_if.sv
// Valid/ready channel interfaces for poll ticks and LED results.
interface tblmc_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        btn1_pressed;
    logic        btn2_pressed;

    modport source (output valid, output now_ms, output btn1_pressed, output btn2_pressed,
                    input ready);
    modport sink (input valid, input now_ms, input btn1_pressed, input btn2_pressed,
                  output ready);
endinterface

interface tblmc_led_if;
    logic       valid;
    logic       ready;
    logic       led1_on;
    logic       led2_on;
    logic [2:0] led_mode;
    logic [3:0] blink_speed;

    modport source (output valid, output led1_on, output led2_on, output led_mode,
                    output blink_speed, input ready);
    modport sink (input valid, input led1_on, input led2_on, input led_mode,
                  input blink_speed, output ready);
endinterface

// File: rtl/tblmc_button.sv
// Per-button edge filter and stability tracker.
module tblmc_button (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [31:0]                now_ms,
    input  logic                       level,
    input  logic [7:0]                 debounce_ms,
    input  logic [9:0]                 stable_ms,
    input  logic                       set_handled,
    output tblmc_pkg::btn_status_t     status
);
    import tblmc_pkg::*;

    logic               prev_reg,    prev_next;
    logic [TimeW-1:0]   edge_ms_reg, edge_ms_next;
    logic [TimeW-1:0]   start_reg,   start_next;
    logic               started_reg, started_next;
    logic               held_reg,    held_next;
    logic               stable_reg,  stable_next;
    logic               handled_reg, handled_next;

    logic               accept;
    logic [TimeW-1:0]   since_edge;
    logic [TimeW-1:0]   since_start;
    logic               handled_a;
    logic               stable_a;
    logic               started_a;

    assign since_edge  = now_ms - edge_ms_reg;
    assign since_start = now_ms - start_reg;

    // filter level changes, then track how long the level holds
    always_comb
    begin
        accept       = (level != prev_reg) &&
                       (since_edge > {{(TimeW-DebounceW){1'b0}}, debounce_ms});
        prev_next    = level;
        edge_ms_next = accept ? now_ms : edge_ms_reg;
        handled_a    = accept ? 1'b0 : handled_reg;
        stable_a     = accept ? 1'b0 : stable_reg;
        started_a    = accept ? 1'b0 : started_reg;

        start_next   = start_reg;
        held_next    = held_reg;
        stable_next  = stable_a;
        started_next = started_a;
        if (!stable_a)
        begin
            if (started_a && (held_reg == level) &&
                (since_start > {{(TimeW-StableW){1'b0}}, stable_ms}))
            begin
                stable_next = 1'b1;
            end
            else if (!started_a || (held_reg != level))
            begin
                start_next   = now_ms;
                held_next    = level;
                stable_next  = 1'b0;
                started_next = 1'b1;
            end
        end

        status.handled = handled_a;
        status.stable  = stable_next;
        status.held    = held_next;
        handled_next   = handled_a | set_handled;
    end

    // commit on each beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= 1'b0;
            edge_ms_reg <= '0;
            start_reg   <= '0;
            started_reg <= 1'b0;
            held_reg    <= 1'b0;
            stable_reg  <= 1'b1;
            handled_reg <= 1'b1;
        end
        else if (advance)
        begin
            prev_reg    <= prev_next;
            edge_ms_reg <= edge_ms_next;
            start_reg   <= start_next;
            started_reg <= started_next;
            held_reg    <= held_next;
            stable_reg  <= stable_next;
            handled_reg <= handled_next;
        end
    end

endmodule

// File: rtl/tblmc_mode_ctl.sv
// LED mode state machine: button events, speed, lead button and blink timer.
module tblmc_mode_ctl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [31:0]                now_ms,
    input  tblmc_pkg::btn_status_t     status1,
    input  tblmc_pkg::btn_status_t     status2,
    output logic                       set_handled1,
    output logic                       set_handled2,
    output logic [1:0]                 leds,
    output tblmc_pkg::led_mode_t       mode,
    output logic [3:0]                 speed
);
    import tblmc_pkg::*;

    typedef struct packed {
        led_mode_t         mode;
        logic [SpeedW-1:0] speed;
        lead_t             lead;
    } ctl_t;

    ctl_t               ctl_reg, ctl_next;
    logic [TimeW-1:0]   toggle_ms_reg, toggle_ms_next;
    logic               phase_reg, phase_next;
    logic [1:0]         leds_reg, leds_next;

    ctl_t               c_both, c_one, c_two;
    logic               ev_both, ev_one, ev_two;
    logic [TimeW-1:0]   elapsed;
    logic [PeriodW-1:0] period;

    function automatic logic [SpeedW-1:0] speed_inc(input logic [SpeedW-1:0] s);
        return (s < SpeedMax) ? s + 1'b1 : s;
    endfunction

    // lead button event for button who
    function automatic ctl_t lead_event(input ctl_t c, input lead_t who);
        ctl_t      r;
        led_mode_t own;
        led_mode_t other;
        r     = c;
        own   = (who == LEAD_BTN1) ? MODE_LED1 : MODE_LED2;
        other = (who == LEAD_BTN1) ? MODE_LED2 : MODE_LED1;
        if (c.lead != who)
        begin
            r.lead = who;
            r.mode = MODE_OFF;
        end
        else if (c.mode == MODE_TOGETHER || c.mode == other || c.mode == MODE_OFF)
        begin
            r.mode = own;
        end
        else if (c.mode == own)
        begin
            r.mode = MODE_BOTH;
        end
        else if (c.mode == MODE_ALT)
        begin
            r.speed = speed_inc(c.speed);
        end
        else if (c.mode == MODE_BOTH)
        begin
            r.speed = '0;
            r.mode  = MODE_ALT;
        end
        return r;
    endfunction

    // events in order: both pressed, button 1 released, button 2 released
    always_comb
    begin
        ev_both = !status1.handled && status1.stable && status1.held &&
                  !status2.handled && status2.stable && status2.held;
        c_both = ctl_reg;
        if (ev_both)
        begin
            if (ctl_reg.mode == MODE_TOGETHER)
            begin
                c_both.speed = speed_inc(ctl_reg.speed);
            end
            else
            begin
                c_both.speed = '0;
                c_both.mode  = MODE_TOGETHER;
            end
        end

        ev_one = !ev_both && !status1.handled && status1.stable && !status1.held;
        c_one  = ev_one ? lead_event(c_both, LEAD_BTN1) : c_both;

        ev_two = !ev_both && !status2.handled && status2.stable && !status2.held;
        c_two  = ev_two ? lead_event(c_one, LEAD_BTN2) : c_one;

        ctl_next     = c_two;
        set_handled1 = ev_both | ev_one;
        set_handled2 = ev_both | ev_two;
    end

    assign elapsed = now_ms - toggle_ms_reg;
    assign period  = blink_period(ctl_next.mode == MODE_ALT, ctl_next.speed);

    // drive LED levels; pace the blinking modes
    always_comb
    begin
        leds_next      = leds_reg;
        phase_next     = phase_reg;
        toggle_ms_next = toggle_ms_reg;
        case (ctl_next.mode)
            MODE_OFF:  leds_next = 2'b00;
            MODE_BOTH: leds_next = 2'b11;
            MODE_LED1: leds_next = 2'b01;
            MODE_LED2: leds_next = 2'b10;
            MODE_ALT, MODE_TOGETHER:
            begin
                if (elapsed > {{(TimeW-PeriodW){1'b0}}, period})
                begin
                    if (ctl_next.mode == MODE_ALT)
                        leds_next = phase_reg ? 2'b10 : 2'b01;
                    else
                        leds_next = phase_reg ? 2'b00 : 2'b11;
                    phase_next     = ~phase_reg;
                    toggle_ms_next = now_ms;
                end
            end
            default: leds_next = leds_reg;
        endcase
    end

    assign leds  = leds_next;
    assign mode  = ctl_next.mode;
    assign speed = ctl_next.speed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.mode  <= MODE_OFF;
            ctl_reg.speed <= SpeedReset;
            ctl_reg.lead  <= LEAD_NONE;
            toggle_ms_reg <= '0;
            phase_reg     <= 1'b0;
            leds_reg      <= 2'b00;
        end
        else if (advance)
        begin
            ctl_reg       <= ctl_next;
            toggle_ms_reg <= toggle_ms_next;
            phase_reg     <= phase_next;
            leds_reg      <= leds_next;
        end
    end

endmodule

// File: rtl/two_button_led_mode_controller.sv
// Two-button LED mode controller: top level with input stage, result register, config.
// Path: a tick held in the input stage moves to the result register once that is free.
// Throughput: one tick per cycle unless the result side stalls; the input stage and the
// result register each hold one beat, and the per-tick logic is one pass of compares and a period lookup.
// Reset: async active low; buttons read not pressed and stable, mode off, speed 1,
// debounce 10 ms, stable time 50 ms.
module two_button_led_mode_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tblmc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tblmc_pkg::CfgDataW-1:0] cfg_data,
    tblmc_tick_if.sink                   tick,
    tblmc_led_if.source                  led
);
    import tblmc_pkg::*;

    logic [DebounceW-1:0] debounce_reg;
    logic [StableW-1:0]   stable_reg;

    logic                 in_valid_reg;
    logic [TimeW-1:0]     now_reg;
    logic                 lvl1_reg;
    logic                 lvl2_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_leds_reg;
    led_mode_t            out_mode_reg;
    logic [SpeedW-1:0]    out_speed_reg;

    logic                 advance;
    btn_status_t          status1;
    btn_status_t          status2;
    logic                 set_handled1;
    logic                 set_handled2;
    logic [1:0]           leds;
    led_mode_t            mode;
    logic [SpeedW-1:0]    speed;

    // move a beat from the input stage when the result register is free
    assign advance        = in_valid_reg && (!out_valid_reg || led.ready);
    assign tick.ready     = !in_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !led.ready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DebounceReset;
            stable_reg   <= StableReset;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DebounceW-1:0];
                CFG_STABLE:   stable_reg   <= cfg_data[StableW-1:0];
                default:      stable_reg   <= stable_reg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick.ready)
            in_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            now_reg  <= tick.now_ms;
            lvl1_reg <= tick.btn1_pressed;
            lvl2_reg <= tick.btn2_pressed;
        end
    end

    tblmc_button u_btn1 (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .now_ms      (now_reg),
        .level       (lvl1_reg),
        .debounce_ms (debounce_reg),
        .stable_ms   (stable_reg),
        .set_handled (set_handled1),
        .status      (status1)
    );

    tblmc_button u_btn2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .now_ms      (now_reg),
        .level       (lvl2_reg),
        .debounce_ms (debounce_reg),
        .stable_ms   (stable_reg),
        .set_handled (set_handled2),
        .status      (status2)
    );

    tblmc_mode_ctl u_mode (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .now_ms       (now_reg),
        .status1      (status1),
        .status2      (status2),
        .set_handled1 (set_handled1),
        .set_handled2 (set_handled2),
        .leds         (leds),
        .mode         (mode),
        .speed        (speed)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_leds_reg  <= leds;
            out_mode_reg  <= mode;
            out_speed_reg <= speed;
        end
    end

    assign led.valid       = out_valid_reg;
    assign led.led1_on     = out_leds_reg[0];
    assign led.led2_on     = out_leds_reg[1];
    assign led.led_mode    = out_mode_reg;
    assign led.blink_speed = out_speed_reg;

endmodule

// File: dv/two_button_led_mode_controller_tb.sv
// Testbench for the two-button LED mode controller: gesture stimulus checked against a predictor.
`timescale 1ns / 100ps

module two_button_led_mode_controller_tb;
    import tblmc_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned BLINK_CYCLE_MS = 2000;
    localparam int unsigned ALT_DIV        = 2;
    localparam int unsigned TOG_DIV        = 5;
    localparam int unsigned RAMP_DEBOUNCE  = 200;
    localparam int unsigned RAMP_STABLE    = 20;
    localparam int unsigned LONG_STALL     = 250;

    typedef struct packed {
        logic               led1;
        logic               led2;
        led_mode_t          mode;
        logic [SpeedW-1:0]  speed;
    } led_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    tblmc_tick_if tick_ch ();
    tblmc_led_if  led_ch ();

    two_button_led_mode_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .led       (led_ch)
    );

    // predicted controller state
    logic [DebounceW-1:0] debounce_cfg = DebounceReset;
    logic [StableW-1:0]   stable_cfg   = StableReset;
    logic                 lvl_last[2]      = '{1'b0, 1'b0};
    logic [TimeW-1:0]     edge_ms[2]       = '{32'd0, 32'd0};
    logic [TimeW-1:0]     hold_start_ms[2] = '{32'd0, 32'd0};
    logic                 tracking[2]      = '{1'b0, 1'b0};
    logic                 held_lvl[2]      = '{1'b0, 1'b0};
    logic                 steady[2]        = '{1'b1, 1'b1};
    logic                 consumed[2]      = '{1'b1, 1'b1};
    led_mode_t            cur_mode  = MODE_OFF;
    logic [SpeedW-1:0]    cur_speed = SpeedReset;
    lead_t                cur_lead  = LEAD_NONE;
    logic [TimeW-1:0]     toggle_ms = '0;
    logic                 phase     = 1'b0;
    logic [1:0]           leds      = 2'b00;

    led_beat_t   led_results_due[$];
    int          fail_count = 0;
    int          ticks_sent = 0;
    int unsigned cycles_run = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned stall_req = 0;
    int unsigned stall_left = 0;
    logic [TimeW-1:0] sim_ms = '0;
    logic drv_b1 = 1'b0;
    logic drv_b2 = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Handle a stable release of one button: lead change, mode step or speed bump
    function automatic void apply_release_event(input lead_t who);
        led_mode_t own_mode;
        led_mode_t rival_mode;
        if (who == LEAD_BTN1)
        begin
            own_mode   = MODE_LED1;
            rival_mode = MODE_LED2;
        end
        else
        begin
            own_mode   = MODE_LED2;
            rival_mode = MODE_LED1;
        end
        if (cur_lead != who)
        begin
            cur_lead = who;
            cur_mode = MODE_OFF;
        end
        else if (cur_mode == MODE_TOGETHER || cur_mode == rival_mode || cur_mode == MODE_OFF)
            cur_mode = own_mode;
        else if (cur_mode == own_mode)
            cur_mode = MODE_BOTH;
        else if (cur_mode == MODE_ALT)
        begin
            if (cur_speed < SpeedMax)
                cur_speed = cur_speed + 1'b1;
        end
        else if (cur_mode == MODE_BOTH)
        begin
            cur_speed = '0;
            cur_mode  = MODE_ALT;
        end
    endfunction

    // Advance the predicted state by one poll tick and return the expected LED beat
    function automatic led_beat_t predict_led_result(input logic [TimeW-1:0] t,
                                                     input logic b1, input logic b2);
        logic             lvl[2];
        logic [TimeW-1:0] since;
        int unsigned      spd;
        int unsigned      pace;
        int               b;
        led_beat_t        res;
        lvl[0] = b1;
        lvl[1] = b2;
        // filter level changes through the debounce window
        for (b = 0; b < 2; b++)
        begin
            if (lvl[b] != lvl_last[b])
            begin
                lvl_last[b] = lvl[b];
                since = t - edge_ms[b];
                if (since > debounce_cfg)
                begin
                    edge_ms[b]  = t;
                    consumed[b] = 1'b0;
                    steady[b]   = 1'b0;
                    tracking[b] = 1'b0;
                end
            end
        end
        // track how long each level has held
        for (b = 0; b < 2; b++)
        begin
            if (!steady[b])
            begin
                since = t - hold_start_ms[b];
                if (tracking[b] && held_lvl[b] == lvl[b] && since > stable_cfg)
                    steady[b] = 1'b1;
                else if (!tracking[b] || held_lvl[b] != lvl[b])
                begin
                    hold_start_ms[b] = t;
                    held_lvl[b]      = lvl[b];
                    steady[b]        = 1'b0;
                    tracking[b]      = 1'b1;
                end
            end
        end
        // fire events: both pressed first, then button 1 release, then button 2 release
        if (!consumed[0] && steady[0] && held_lvl[0] && !consumed[1] && steady[1] && held_lvl[1])
        begin
            if (cur_mode == MODE_TOGETHER)
            begin
                if (cur_speed < SpeedMax)
                    cur_speed = cur_speed + 1'b1;
            end
            else
            begin
                cur_speed = '0;
                cur_mode  = MODE_TOGETHER;
            end
            consumed[0] = 1'b1;
            consumed[1] = 1'b1;
        end
        if (!consumed[0] && steady[0] && !held_lvl[0])
        begin
            apply_release_event(LEAD_BTN1);
            consumed[0] = 1'b1;
        end
        if (!consumed[1] && steady[1] && !held_lvl[1])
        begin
            apply_release_event(LEAD_BTN2);
            consumed[1] = 1'b1;
        end
        // drive the LEDs, pacing the blink modes
        spd = cur_speed;
        if (spd < 1)
            spd = 1;
        if (spd > SpeedMax)
            spd = SpeedMax;
        case (cur_mode)
            MODE_OFF:  leds = 2'b00;
            MODE_BOTH: leds = 2'b11;
            MODE_LED1: leds = 2'b01;
            MODE_LED2: leds = 2'b10;
            MODE_ALT, MODE_TOGETHER:
            begin
                pace  = BLINK_CYCLE_MS / (((cur_mode == MODE_ALT) ? ALT_DIV : TOG_DIV) * spd);
                since = t - toggle_ms;
                if (since > pace)
                begin
                    if (cur_mode == MODE_ALT)
                        leds = phase ? 2'b10 : 2'b01;
                    else
                        leds = phase ? 2'b00 : 2'b11;
                    phase     = ~phase;
                    toggle_ms = t;
                end
            end
            default: ;
        endcase
        res.led1  = leds[0];
        res.led2  = leds[1];
        res.mode  = cur_mode;
        res.speed = cur_speed;
        return res;
    endfunction

    // Offer one tick beat, wait for it to be taken, queue its expected result
    task automatic send_tick(input logic [TimeW-1:0] t, input logic b1, input logic b2);
        while ($urandom_range(99) < send_gap_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.now_ms       <= t;
        tick_ch.btn1_pressed <= b1;
        tick_ch.btn2_pressed <= b2;
        drv_b1 = b1;
        drv_b2 = b2;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        led_results_due.push_back(predict_led_result(t, b1, b2));
        ticks_sent++;
    endtask

    task automatic tick_at(input int unsigned delta, input logic b1, input logic b2);
        sim_ms = sim_ms + delta;
        send_tick(sim_ms, b1, b2);
    endtask

    // Step large enough that every change passes debounce and two steps pass the stable time
    function automatic int unsigned settle_step();
        int unsigned base;
        base = (debounce_cfg > stable_cfg / 2) ? debounce_cfg : stable_cfg / 2;
        return base + 1 + $urandom_range(0, 3);
    endfunction

    task automatic hold_levels(input logic b1, input logic b2, input int n);
        repeat (n)
            tick_at(settle_step(), b1, b2);
    endtask

    task automatic press_release(input int sel, input int n);
        hold_levels(sel == 1, sel == 2, n);
        hold_levels(1'b0, 1'b0, n);
    endtask

    task automatic watch_blink(input int n);
        repeat (n)
            tick_at(($urandom_range(3) == 0) ? $urandom_range(300, 1100) : $urandom_range(1, 130),
                    drv_b1, drv_b2);
    endtask

    // Drop valid and hold until every expected beat has come back
    task automatic wait_results_drained();
        tick_ch.valid <= 1'b0;
        while (led_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            debounce_cfg = val[DebounceW-1:0];
        else
            stable_cfg = val[StableW-1:0];
    endtask

    // Debounce and stable boundaries, time wrap, speed zero pacing, event order
    task automatic test_directed();
        send_tick(32'd0, 1'b0, 1'b0);
        send_tick(32'd5, 1'b1, 1'b0);
        send_tick(32'd10, 1'b0, 1'b0);
        send_tick(32'd11, 1'b1, 1'b0);
        send_tick(32'd61, 1'b1, 1'b0);
        send_tick(32'd62, 1'b1, 1'b0);
        send_tick(32'd73, 1'b0, 1'b0);
        send_tick(32'd124, 1'b0, 1'b0);
        send_tick(32'hFFFF_FFF0, 1'b1, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_tick(32'd40, 1'b1, 1'b1);
        send_tick(32'd500, 1'b1, 1'b1);
        send_tick(32'd900, 1'b1, 1'b1);
        send_tick(32'd901, 1'b1, 1'b1);
        send_tick(32'd920, 1'b0, 1'b1);
        send_tick(32'd971, 1'b0, 1'b1);
        send_tick(32'd990, 1'b0, 1'b0);
        send_tick(32'd1041, 1'b0, 1'b0);
        sim_ms = 32'd1041;
    endtask

    // Walk every mode and ramp the alternate speed past saturation
    task automatic test_mode_walk();
        repeat (3) press_release(2, 3);
        watch_blink(8);
        repeat (12) press_release(2, 3);
        watch_blink(6);
        repeat (4) press_release(1, 3);
        hold_levels(1'b1, 1'b1, 3);
        hold_levels(1'b0, 1'b0, 3);
    endtask

    // Repeat both-pressed events with releases swallowed by a long debounce
    task automatic test_together_ramp();
        write_reg(CFG_DEBOUNCE, CfgDataW'(RAMP_DEBOUNCE));
        write_reg(CFG_STABLE, CfgDataW'(RAMP_STABLE));
        repeat (13)
        begin
            tick_at(RAMP_DEBOUNCE + 1 + $urandom_range(0, 50), 1'b1, 1'b1);
            tick_at(RAMP_STABLE / 2 + 1, 1'b1, 1'b1);
            tick_at(RAMP_STABLE / 2 + 1, 1'b1, 1'b1);
            tick_at(RAMP_STABLE / 2 + 1 + $urandom_range(0, 100), 1'b0, 1'b0);
        end
    endtask

    // Mostly well-formed gestures with random timing, plus bounce, noise and wrap
    task automatic test_random_gestures(input int count);
        int stop_at;
        int pick;
        int sel;
        stop_at = ticks_sent + count;
        while (ticks_sent < stop_at)
        begin
            pick = $urandom_range(99);
            sel  = $urandom_range(1, 2);
            if (pick < 35)
                press_release(sel, $urandom_range(2, 5));
            else if (pick < 50)
            begin
                hold_levels(1'b1, 1'b1, $urandom_range(2, 5));
                if ($urandom_range(1))
                    hold_levels(sel == 2, sel == 1, $urandom_range(1, 4));
                hold_levels(1'b0, 1'b0, $urandom_range(2, 4));
            end
            else if (pick < 62)
            begin
                hold_levels(sel == 1, sel == 2, $urandom_range(1, 3));
                hold_levels(1'b1, 1'b1, $urandom_range(2, 4));
                hold_levels(sel == 2, sel == 1, $urandom_range(1, 4));
                hold_levels(1'b0, 1'b0, $urandom_range(2, 4));
            end
            else if (pick < 72)
            begin
                // chatter on one button, then let it settle
                repeat ($urandom_range(2, 6))
                begin
                    if (sel == 1)
                        tick_at($urandom_range(0, 4), ~drv_b1, drv_b2);
                    else
                        tick_at($urandom_range(0, 4), drv_b1, ~drv_b2);
                end
                hold_levels(drv_b1, drv_b2, 3);
            end
            else if (pick < 84)
                watch_blink($urandom_range(3, 10));
            else if (pick < 94)
            begin
                repeat ($urandom_range(1, 3))
                    send_tick($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    sim_ms = $urandom;
            end
            else
            begin
                sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
                press_release(sel, 3);
            end
        end
    endtask

    // Stall the result side long enough to back up the tick input, then drain
    task automatic test_backpressure();
        stall_req = LONG_STALL;
        test_random_gestures(40);
        wait_results_drained();
    endtask

    // Drive result ready and check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        led_beat_t want;
        if (rst_n && led_ch.valid && led_ch.ready)
        begin
            if (led_results_due.size() == 0)
            begin
                $error("LED result beat with no tick waiting");
                fail_count++;
            end
            else
            begin
                want = led_results_due.pop_front();
                if (led_ch.led1_on !== want.led1)
                begin
                    $error("led1_on: expected %0d, got %0d", want.led1, led_ch.led1_on);
                    fail_count++;
                end
                if (led_ch.led2_on !== want.led2)
                begin
                    $error("led2_on: expected %0d, got %0d", want.led2, led_ch.led2_on);
                    fail_count++;
                end
                if (led_ch.led_mode !== want.mode)
                begin
                    $error("led_mode: expected %0d, got %0d", want.mode, led_ch.led_mode);
                    fail_count++;
                end
                if (led_ch.blink_speed !== want.speed)
                begin
                    $error("blink_speed: expected %0d, got %0d", want.speed, led_ch.blink_speed);
                    fail_count++;
                end
            end
        end
        if (stall_req != 0)
        begin
            stall_left = stall_req;
            stall_req  = 0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            led_ch.ready <= 1'b0;
        end
        else
            led_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Bound the run
    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_DEBOUNCE;
        cfg_data             = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.now_ms       = '0;
        tick_ch.btn1_pressed = 1'b0;
        tick_ch.btn2_pressed = 1'b0;
        led_ch.ready         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles rarely, receiver often
        send_gap_pct = 13;
        recv_gap_pct = 61;
        test_directed();
        test_mode_walk();
        test_random_gestures(300);
        write_reg(CFG_DEBOUNCE, CfgDataW'(0));
        write_reg(CFG_STABLE, CfgDataW'(0));
        test_random_gestures(200);

        // sender idles often, receiver rarely
        send_gap_pct = 61;
        recv_gap_pct = 13;
        write_reg(CFG_DEBOUNCE, CfgDataW'(255));
        write_reg(CFG_STABLE, CfgDataW'(1023));
        test_random_gestures(150);
        test_together_ramp();
        test_random_gestures(150);

        // no idling on either side
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_reg(CFG_DEBOUNCE, CfgDataW'($urandom_range(0, 255)));
        write_reg(CFG_STABLE, CfgDataW'($urandom_range(0, 300)));
        test_backpressure();
        test_random_gestures(400);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: two_button_led_mode_controller.f
rtl/tblmc_pkg.sv
rtl/tblmc_if.sv
rtl/tblmc_button.sv
rtl/tblmc_mode_ctl.sv
rtl/two_button_led_mode_controller.sv
dv/two_button_led_mode_controller_tb.sv
